// File: rtl/swm_pkg.sv
// Shared constants and control types of the sliding window median filter.
`timescale 1ns / 1ps
`default_nettype none

package swm_pkg;

    // Default sizes
    localparam int SWM_WINDOW_MAX   = 64;
    localparam int SWM_SAMPLE_WIDTH = 16;

    // Configuration register
    localparam int              CFG_WIDTH        = 7;
    localparam logic [0:0]      ADDR_WINDOW_SIZE = 1'b0;
    localparam logic [CFG_WIDTH-1:0] WINDOW_SIZE_RST = 7'd3;

    // Broadcast control from the sequencer to every cell of the sorted chain
    typedef struct packed {
        logic clear;   // drop every entry of the window
        logic load;    // take the next sorted state
        logic evict;   // window full: remove the oldest sample first
    } swm_ctl_t;

endpackage

`default_nettype wire

// File: rtl/swm_cell.sv
// One cell of the sorted window chain: holds one sample and its valid flag.
`timescale 1ns / 1ps
`default_nettype none

module swm_cell
    import swm_pkg::*;
#(
    parameter int WIDTH = SWM_SAMPLE_WIDTH
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire swm_ctl_t                ctl,
    input  wire logic signed [WIDTH-1:0] sample,
    input  wire logic signed [WIDTH-1:0] oldest,
    input  wire logic signed [WIDTH-1:0] left_val,
    input  wire logic                    left_vld,
    input  wire logic                    left_past_old,
    input  wire logic                    left_shift_above,
    input  wire logic signed [WIDTH-1:0] right_val,
    input  wire logic                    right_vld,
    input  wire logic                    right_above,
    output logic signed [WIDTH-1:0]      val,
    output logic                         vld,
    output logic                         past_old,
    output logic                         above,
    output logic                         shift_above
);

    logic signed [WIDTH-1:0] val_reg;
    logic signed [WIDTH-1:0] val_next;
    logic                    vld_reg;
    logic                    vld_next;
    logic signed [WIDTH-1:0] own_w_val;
    logic                    own_w_vld;
    logic signed [WIDTH-1:0] left_w_val;
    logic                    left_w_vld;

    assign val = val_reg;
    assign vld = vld_reg;

    // Empty cells count as larger than any sample
    assign past_old = ctl.evict && (!vld_reg || (val_reg >= oldest));
    assign above    = !vld_reg || (val_reg > sample);

    // Entry at this place once the oldest sample is taken out
    always_comb
    begin
        if (past_old)
        begin
            own_w_val = right_val;
            own_w_vld = right_vld;
        end
        else
        begin
            own_w_val = val_reg;
            own_w_vld = vld_reg;
        end
        if (left_past_old)
        begin
            left_w_val = val_reg;
            left_w_vld = vld_reg;
        end
        else
        begin
            left_w_val = left_val;
            left_w_vld = left_vld;
        end
    end

    assign shift_above = past_old ? right_above : above;

    // Insert the new sample: shift right past it, take it at its place
    always_comb
    begin
        if (left_shift_above)
        begin
            val_next = left_w_val;
            vld_next = left_w_vld;
        end
        else if (shift_above)
        begin
            val_next = sample;
            vld_next = 1'b1;
        end
        else
        begin
            val_next = own_w_val;
            vld_next = own_w_vld;
        end
    end

    // Hold the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (ctl.clear)
        begin
            vld_reg <= 1'b0;
        end
        else if (ctl.load)
        begin
            vld_reg <= vld_next;
        end
    end

    // Hold the sample value
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            val_reg <= val_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/swm_history.sv
// Arrival-order history memory with registered read and write bypass.
`timescale 1ns / 1ps
`default_nettype none

module swm_history
    import swm_pkg::*;
#(
    parameter int DEPTH = SWM_WINDOW_MAX,
    parameter int WIDTH = SWM_SAMPLE_WIDTH,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0]      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_reg;
    logic [WIDTH-1:0] byp_data_reg;
    logic             byp_reg;
    logic             byp_next;

    assign byp_next = we && (waddr == raddr);
    assign rdata    = byp_reg ? byp_data_reg : rd_reg;

    // Write and read the memory
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_reg       <= mem[raddr];
        byp_data_reg <= wdata;
    end

    // Track a read of the address being written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_reg <= 1'b0;
        end
        else
        begin
            byp_reg <= byp_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/sliding_window_median_top.sv
// Sliding window lower median filter: sorted cell chain, history memory, output stage.
// Output: the chain and pend_reg load with the completing sample; median_reg loads after.
// Throughput: one sample per cycle unless stalled; every chain cell updates in the same cycle.
// The first window_size-1 samples after reset or a window_size write give no result.
// Reset: window_size returns to 3 and the window is empty; no clearing pass is needed.
// History memory contents are undefined after reset and are written before they are read.
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_median_top
    import swm_pkg::*;
#(
    parameter int WINDOW_MAX   = SWM_WINDOW_MAX,
    parameter int SAMPLE_WIDTH = SWM_SAMPLE_WIDTH
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // Sample channel
    input  wire logic                           sample_valid,
    output logic                                sample_stall,
    input  wire logic signed [SAMPLE_WIDTH-1:0] sample,
    // Median channel
    output logic                                median_valid,
    input  wire logic                           median_stall,
    output logic signed [SAMPLE_WIDTH-1:0]      median,
    // Configuration port
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [0:0]                     paddr,
    input  wire logic [31:0]                    pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    localparam int KW = $clog2(WINDOW_MAX + 1);
    localparam int IW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CW = (KW > CFG_WIDTH) ? KW : CFG_WIDTH;

    logic [CFG_WIDTH-1:0]           window_size_reg;
    logic [KW-1:0]                  k;
    logic [KW-1:0]                  mid;
    logic [KW-1:0]                  fill_reg;
    logic [KW-1:0]                  fill_next;
    logic [KW-1:0]                  fill_inc;
    logic [IW-1:0]                  ptr_reg;
    logic [IW-1:0]                  ptr_next;
    logic [KW-1:0]                  ptr_inc;
    logic                           pend_reg;
    logic                           pend_next;
    logic                           median_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] median_reg;
    logic                           cfg_wr;
    logic                           accept;
    logic                           full;
    logic                           emit;
    logic                           out_load;
    logic [IW-1:0]                  hist_waddr;
    logic [SAMPLE_WIDTH-1:0]        oldest_raw;
    logic signed [SAMPLE_WIDTH-1:0] oldest;
    swm_ctl_t                       ctl;

    // Chain wiring, one entry per cell plus the right boundary
    logic signed [SAMPLE_WIDTH-1:0] cell_val [WINDOW_MAX+1];
    logic                           cell_vld [WINDOW_MAX+1];
    logic                           cell_above [WINDOW_MAX+1];
    logic                           cell_past_old [WINDOW_MAX];
    logic                           cell_shift_above [WINDOW_MAX];

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_WINDOW_SIZE);
    assign prdata = (paddr == ADDR_WINDOW_SIZE) ? {{(32 - CFG_WIDTH){1'b0}}, window_size_reg}
                                                : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= WINDOW_SIZE_RST;
        end
        else if (cfg_wr)
        begin
            window_size_reg <= pwdata[CFG_WIDTH-1:0];
        end
    end

    // Effective window length and median place
    always_comb
    begin
        if (window_size_reg == '0)
        begin
            k = KW'(1);
        end
        else if (CW'(window_size_reg) > CW'(WINDOW_MAX))
        begin
            k = KW'(WINDOW_MAX);
        end
        else
        begin
            k = KW'(window_size_reg);
        end
    end

    assign mid = (k - KW'(1)) >> 1;

    // Transfer and sequencing
    assign sample_stall = pend_reg && median_valid_reg && median_stall;
    assign accept       = sample_valid && !sample_stall;
    assign full         = (fill_reg == k);
    assign fill_inc     = fill_reg + KW'(1);
    assign ptr_inc      = KW'(ptr_reg) + KW'(1);
    assign emit         = accept && (full || (fill_inc == k));
    assign out_load     = pend_reg && (!median_valid_reg || !median_stall);

    assign ctl.clear = cfg_wr;
    assign ctl.load  = accept;
    assign ctl.evict = full;

    always_comb
    begin
        fill_next = fill_reg;
        ptr_next  = ptr_reg;
        if (cfg_wr)
        begin
            fill_next = '0;
            ptr_next  = '0;
        end
        else if (accept)
        begin
            if (full)
            begin
                ptr_next = (ptr_inc == k) ? '0 : IW'(ptr_inc);
            end
            else
            begin
                fill_next = fill_inc;
            end
        end
    end

    assign pend_next  = accept ? emit : (pend_reg && !out_load);
    assign hist_waddr = full ? ptr_reg : IW'(fill_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            ptr_reg  <= '0;
            pend_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            ptr_reg  <= ptr_next;
            pend_reg <= pend_next && !cfg_wr;
        end
    end

    // History in arrival order; read ahead at the oldest place
    swm_history #(
        .DEPTH (WINDOW_MAX),
        .WIDTH (SAMPLE_WIDTH),
        .AW    (IW)
    ) u_history (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (accept),
        .waddr (hist_waddr),
        .wdata (sample),
        .raddr (ptr_next),
        .rdata (oldest_raw)
    );

    assign oldest = oldest_raw;

    // Right chain boundary
    assign cell_val[WINDOW_MAX]   = '0;
    assign cell_vld[WINDOW_MAX]   = 1'b0;
    assign cell_above[WINDOW_MAX] = 1'b1;

    // Sorted chain of cells
    for (genvar i = 0; i < WINDOW_MAX; i++)
    begin : g_cell
        logic signed [SAMPLE_WIDTH-1:0] l_val;
        logic                           l_vld;
        logic                           l_past_old;
        logic                           l_shift_above;

        if (i == 0)
        begin : g_first
            assign l_val         = '0;
            assign l_vld         = 1'b0;
            assign l_past_old    = 1'b0;
            assign l_shift_above = 1'b0;
        end
        else
        begin : g_inner
            assign l_val         = cell_val[i-1];
            assign l_vld         = cell_vld[i-1];
            assign l_past_old    = cell_past_old[i-1];
            assign l_shift_above = cell_shift_above[i-1];
        end

        swm_cell #(
            .WIDTH (SAMPLE_WIDTH)
        ) u_cell (
            .clk              (clk),
            .rst_n            (rst_n),
            .ctl              (ctl),
            .sample           (sample),
            .oldest           (oldest),
            .left_val         (l_val),
            .left_vld         (l_vld),
            .left_past_old    (l_past_old),
            .left_shift_above (l_shift_above),
            .right_val        (cell_val[i+1]),
            .right_vld        (cell_vld[i+1]),
            .right_above      (cell_above[i+1]),
            .val              (cell_val[i]),
            .vld              (cell_vld[i]),
            .past_old         (cell_past_old[i]),
            .above            (cell_above[i]),
            .shift_above      (cell_shift_above[i])
        );
    end

    // Output register: take the median tap once the chain has settled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            median_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            median_valid_reg <= 1'b1;
        end
        else if (!median_stall)
        begin
            median_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            median_reg <= cell_val[mid];
        end
    end

    assign median_valid = median_valid_reg;
    assign median       = median_reg;

endmodule

`default_nettype wire
